// ----- rtl/lpis_pkg.sv -----
package lpis_pkg;

    localparam int MAX_VALUES = 4096;
    localparam int ADDR_W     = $clog2(MAX_VALUES);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int COUNT_W    = 13;
    localparam int LEN_W      = (COUNT_W > FILL_W) ? COUNT_W : FILL_W;
    localparam int OFFSET_W   = 31;
    localparam int SPAN_W     = OFFSET_W + 1;
    localparam int BASE_W     = 46;
    localparam int IDX_W      = 47;
    localparam int MEM_W      = IDX_W + 1;
    localparam int PIDX_W     = 48;
    localparam int CNTR_W     = 32;
    localparam int SLOT_W     = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] CMD_ELEMENT = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] MODE_LIST   = 2'd0;
    localparam logic [1:0] MODE_VIEW   = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_SHARED = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PARENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUES_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LEN   = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [OFFSET_W-1:0] value_offset;
        logic [COUNT_W-1:0]  value_count;
        logic                element_valid;
        logic [SLOT_W-1:0]   slot_address;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [PIDX_W-1:0] parent_index;
        logic                     index_valid;
    } out_t;

    typedef struct packed {
        logic [1:0]          list_mode;
        logic [BASE_W-1:0]   base_parent;
        logic [OFFSET_W-1:0] values_base;
        logic [COUNT_W-1:0]  fixed_len;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [MEM_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ----- rtl/list_parent_index_scatter.sv -----
// Channel   Direction  Handshake                      Payload
// item      in         start & !busy                  lpis_pkg::in_t
// result    out        done, one cycle, no back-off   lpis_pkg::out_t
// cfg       in         cfg_valid & cfg_ready          cfg_index, cfg_data
//
// An element is accepted, range checked, then every slot of its range is read to check
// for a claim and every slot written, through the one read port and one write port of
// the slot store. A skipped element, or one met by a held error, ends at acceptance, a
// range failure at the range check, and a clash at the first claimed value of the range.
// A read ends with the slot read; a clear clears one slot per cycle, and after reset the
// same pass over all 4096 slots runs with busy high. Results cannot be stalled.
module list_parent_index_scatter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lpis_pkg::in_t                     item,
    output logic                              done,
    output lpis_pkg::out_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpis_pkg::BASE_W-1:0]       cfg_data
);

    lpis_pkg::cfg_t                cfg_reg;
    lpis_pkg::mem_req_t            req;
    logic [lpis_pkg::MEM_W-1:0]    rd_data;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.list_mode   <= lpis_pkg::MODE_LIST;
            cfg_reg.base_parent <= '0;
            cfg_reg.values_base <= '0;
            cfg_reg.fixed_len   <= lpis_pkg::COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lpis_pkg::CFG_LIST_MODE:
                    cfg_reg.list_mode <= cfg_data[1:0];
                lpis_pkg::CFG_BASE_PARENT:
                    cfg_reg.base_parent <= cfg_data;
                lpis_pkg::CFG_VALUES_BASE:
                    cfg_reg.values_base <= cfg_data[lpis_pkg::OFFSET_W-1:0];
                lpis_pkg::CFG_FIXED_LEN:
                    cfg_reg.fixed_len <= cfg_data[lpis_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lpis_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    lpis_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule

// ----- rtl/lpis_mem.sv -----
module lpis_mem (
    input  logic                         clk,
    input  lpis_pkg::mem_req_t           req,
    output logic [lpis_pkg::MEM_W-1:0]   rd_data
);

    logic [lpis_pkg::MEM_W-1:0] mem [lpis_pkg::MAX_VALUES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- rtl/lpis_seq.sv -----
module lpis_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lpis_pkg::in_t                item,
    input  lpis_pkg::cfg_t               cfg,
    input  logic [lpis_pkg::MEM_W-1:0]   rd_data,
    output lpis_pkg::mem_req_t           req,
    output logic                         busy,
    output logic                         done,
    output lpis_pkg::out_t               result
);

    localparam int ADDR_W = lpis_pkg::ADDR_W;
    localparam int LEN_W  = lpis_pkg::LEN_W;
    localparam int SPAN_W = lpis_pkg::SPAN_W;
    localparam int MEM_W  = lpis_pkg::MEM_W;
    localparam int IDX_W  = lpis_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RANGE,
        S_CHECK,
        S_WRITE,
        S_READ
    } state_t;

    state_t                          state_reg;
    logic [LEN_W-1:0]                ptr_reg;
    logic [LEN_W-1:0]                count_reg;
    logic [SPAN_W-1:0]               start_reg;
    logic [SPAN_W-1:0]               end_reg;
    logic                            under_reg;
    logic                            oor_reg;
    logic                            pend_reg;
    logic                            clr_rep_reg;
    logic [IDX_W-1:0]                parent_reg;
    logic [lpis_pkg::CNTR_W-1:0]     counter_reg;
    logic [lpis_pkg::FILL_W-1:0]     fill_reg;
    logic [1:0]                      err_reg;
    logic                            done_reg;
    logic [lpis_pkg::PIDX_W-1:0]     pidx_reg;
    logic                            pvalid_reg;

    logic [SPAN_W-1:0] opb;
    logic [SPAN_W-1:0] sum;
    logic [SPAN_W-1:0] diff;
    logic [IDX_W-1:0]  parent_sum;
    logic              more;
    logic              range_bad;

    // one adder serves the range end, the slot address and the fill update
    assign opb  = (state_reg == S_RANGE) ? SPAN_W'(count_reg) : SPAN_W'(ptr_reg);
    assign sum  = start_reg + opb;
    assign more = (ptr_reg != count_reg);

    assign diff       = {1'b0, item.value_offset} - {1'b0, cfg.values_base};
    assign parent_sum = {1'b0, cfg.base_parent} + IDX_W'(counter_reg);
    assign range_bad  = under_reg
                     || (start_reg > SPAN_W'(lpis_pkg::MAX_VALUES))
                     || (sum > SPAN_W'(lpis_pkg::MAX_VALUES));

    always_comb
    begin
        req.wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && more);
        req.wr_addr = (state_reg == S_CLEAR) ? ptr_reg[ADDR_W-1:0] : sum[ADDR_W-1:0];
        req.wr_data = (state_reg == S_CLEAR) ? '0 : {1'b1, parent_reg};
        req.rd_en   = ((state_reg == S_IDLE) && start && (item.command == lpis_pkg::CMD_READ))
                   || ((state_reg == S_CHECK) && more);
        req.rd_addr = (state_reg == S_IDLE) ? ADDR_W'(item.slot_address) : sum[ADDR_W-1:0];
    end

    assign busy                = (state_reg != S_IDLE);
    assign done                = done_reg;
    assign result.status       = err_reg;
    assign result.parent_index = pidx_reg;
    assign result.index_valid  = pvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            clr_rep_reg <= 1'b0;
            counter_reg <= '0;
            fill_reg    <= '0;
            err_reg     <= lpis_pkg::STAT_OK;
            done_reg    <= 1'b0;
            pidx_reg    <= '0;
            pvalid_reg  <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            pidx_reg   <= '0;
            pvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (item.command)
                            lpis_pkg::CMD_ELEMENT:
                            begin
                                if (err_reg != lpis_pkg::STAT_OK)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else if ((cfg.list_mode == lpis_pkg::MODE_LIST)
                                      || ((cfg.list_mode == lpis_pkg::MODE_VIEW)
                                          && item.element_valid))
                                begin
                                    start_reg  <= diff;
                                    under_reg  <= diff[SPAN_W-1];
                                    count_reg  <= LEN_W'(item.value_count);
                                    parent_reg <= parent_sum;
                                    state_reg  <= S_RANGE;
                                end
                                else if ((cfg.list_mode == lpis_pkg::MODE_FIXED)
                                      && item.element_valid)
                                begin
                                    start_reg  <= SPAN_W'(fill_reg);
                                    under_reg  <= 1'b0;
                                    count_reg  <= LEN_W'(cfg.fixed_len);
                                    parent_reg <= parent_sum;
                                    state_reg  <= S_RANGE;
                                end
                                else
                                begin
                                    // skipped element: count it only
                                    counter_reg <= counter_reg + 1'b1;
                                    done_reg    <= 1'b1;
                                end
                            end
                            lpis_pkg::CMD_READ:
                            begin
                                oor_reg   <= (SPAN_W'(item.slot_address)
                                              >= SPAN_W'(lpis_pkg::MAX_VALUES));
                                state_reg <= S_READ;
                            end
                            lpis_pkg::CMD_CLEAR:
                            begin
                                counter_reg <= '0;
                                fill_reg    <= '0;
                                err_reg     <= lpis_pkg::STAT_OK;
                                ptr_reg     <= '0;
                                clr_rep_reg <= 1'b1;
                                state_reg   <= S_CLEAR;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RANGE:
                begin
                    end_reg <= sum;
                    if (range_bad)
                    begin
                        err_reg   <= lpis_pkg::STAT_RANGE;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // reads are issued back to back; each read's data is checked in the cycle after it is issued
                    if (pend_reg && rd_data[MEM_W-1])
                    begin
                        err_reg   <= lpis_pkg::STAT_SHARED;
                        pend_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!more)
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            ptr_reg   <= '0;
                            state_reg <= S_WRITE;
                        end
                    end
                    else
                    begin
                        ptr_reg  <= ptr_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                end
                S_WRITE:
                begin
                    if (more)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        counter_reg <= counter_reg + 1'b1;
                        if (cfg.list_mode == lpis_pkg::MODE_FIXED)
                        begin
                            fill_reg <= end_reg[lpis_pkg::FILL_W-1:0];
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (!oor_reg && rd_data[MEM_W-1])
                    begin
                        pidx_reg   <= {1'b0, rd_data[IDX_W-1:0]};
                        pvalid_reg <= 1'b1;
                    end
                    else
                    begin
                        pidx_reg <= '1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_CLEAR:
                begin
                    if (ptr_reg[ADDR_W-1:0] == ADDR_W'(lpis_pkg::MAX_VALUES - 1))
                    begin
                        done_reg    <= clr_rep_reg;
                        clr_rep_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- test/list_parent_index_scatter_tb.sv -----
module list_parent_index_scatter_tb;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int ITEM_GOAL   = 1150;
    localparam int SHOWN_MAX   = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        bit                             is_reg;
        logic [lpis_pkg::CFG_IDX_W-1:0] reg_index;
        logic [lpis_pkg::BASE_W-1:0]    reg_value;
        lpis_pkg::in_t                  stim;
        bit                             pinned;
        lpis_pkg::out_t                 golden;
    } step_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    lpis_pkg::in_t                  item;
    logic                           done;
    lpis_pkg::out_t                 result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lpis_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lpis_pkg::BASE_W-1:0]    cfg_data;

    // shadow of the block's registers and state
    logic [1:0]                     mode_q;
    logic [lpis_pkg::BASE_W-1:0]    base_parent_q;
    logic [lpis_pkg::OFFSET_W-1:0]  values_base_q;
    logic [lpis_pkg::COUNT_W-1:0]   fixed_len_q;
    bit                             slot_taken [lpis_pkg::MAX_VALUES];
    logic [lpis_pkg::IDX_W-1:0]     slot_parent [lpis_pkg::MAX_VALUES];
    logic [lpis_pkg::CNTR_W-1:0]    element_count;
    int unsigned                    fill_pos;
    logic [1:0]                     sticky_status;

    lpis_pkg::out_t                 parent_results_due [$];
    step_t                          directed_steps [$];
    bit                             pin_now;
    lpis_pkg::out_t                 pin_golden;
    int                             mismatches;
    int                             items_sent;
    int                             idle_pct;

    list_parent_index_scatter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("list_parent_index_scatter_tb: FAIL");
        $finish;
    end

    function automatic void clear_shadow();
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        element_count = '0;
        fill_pos      = 0;
        sticky_status = lpis_pkg::STAT_OK;
    endfunction

    function automatic logic [1:0] claim_slots(int unsigned first, int unsigned span);
        logic [lpis_pkg::IDX_W-1:0] parent;
        if (first > lpis_pkg::MAX_VALUES || span > lpis_pkg::MAX_VALUES - first)
            return lpis_pkg::STAT_RANGE;
        for (int unsigned k = 0; k < span; k++)
            if (slot_taken[first + k])
                return lpis_pkg::STAT_SHARED;
        parent = lpis_pkg::IDX_W'(base_parent_q) + lpis_pkg::IDX_W'(element_count);
        for (int unsigned k = 0; k < span; k++)
        begin
            slot_taken[first + k]  = 1'b1;
            slot_parent[first + k] = parent;
        end
        return lpis_pkg::STAT_OK;
    endfunction

    function automatic lpis_pkg::out_t predict_scatter(lpis_pkg::in_t it);
        lpis_pkg::out_t r;
        logic [1:0]     fault;
        r     = '0;
        fault = lpis_pkg::STAT_OK;
        case (it.command)
            lpis_pkg::CMD_ELEMENT:
                if (sticky_status == lpis_pkg::STAT_OK)
                begin
                    if (mode_q == lpis_pkg::MODE_LIST
                        || (mode_q == lpis_pkg::MODE_VIEW && it.element_valid))
                    begin
                        if (it.value_offset < values_base_q)
                            fault = lpis_pkg::STAT_RANGE;
                        else
                            fault = claim_slots(it.value_offset - values_base_q,
                                                it.value_count);
                    end
                    else if (mode_q == lpis_pkg::MODE_FIXED && it.element_valid)
                    begin
                        fault = claim_slots(fill_pos, fixed_len_q);
                        if (fault == lpis_pkg::STAT_OK)
                            fill_pos = fill_pos + fixed_len_q;
                    end
                    // a rejected element is not counted
                    if (fault != lpis_pkg::STAT_OK)
                        sticky_status = fault;
                    else
                        element_count = element_count + 1'b1;
                end
            lpis_pkg::CMD_READ:
                if (slot_taken[it.slot_address])
                begin
                    r.parent_index = {1'b0, slot_parent[it.slot_address]};
                    r.index_valid  = 1'b1;
                end
                else
                    r.parent_index = '1;
            lpis_pkg::CMD_CLEAR:
                clear_shadow();
            default: ;
        endcase
        r.status = sticky_status;
        return r;
    endfunction

    always @(posedge clk)
    begin
        lpis_pkg::out_t want;
        if (rst_n && start && !busy)
        begin
            want = predict_scatter(item);
            parent_results_due.insert(parent_results_due.size(),
                                      pin_now ? pin_golden : want);
        end
        if (rst_n && done)
        begin
            if (parent_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("unexpected result: status %0d parent %0d valid %0b",
                             result.status, result.parent_index, result.index_valid);
            end
            else
            begin
                want = parent_results_due.pop_front();
                if (result.status !== want.status
                    || result.parent_index !== want.parent_index
                    || result.index_valid !== want.index_valid)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("mismatch: status %0d/%0d parent %0d/%0d valid %0b/%0b",
                                 result.status, want.status,
                                 result.parent_index, want.parent_index,
                                 result.index_valid, want.index_valid);
                end
            end
        end
    end

    // offer one transaction, dropping start at random cycles until it is taken
    task automatic send_item(input lpis_pkg::in_t it, input bit pinned,
                             input lpis_pkg::out_t golden);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            if ($urandom_range(0, 99) < idle_pct)
                start <= 1'b0;
            else
            begin
                start      <= 1'b1;
                item       <= it;
                pin_now    <= pinned;
                pin_golden <= golden;
            end
            @(posedge clk);
            taken = start && !busy;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (parent_results_due.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic [lpis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpis_pkg::BASE_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            lpis_pkg::CFG_LIST_MODE:   mode_q        = value[1:0];
            lpis_pkg::CFG_BASE_PARENT: base_parent_q = value;
            lpis_pkg::CFG_VALUES_BASE: values_base_q = value[lpis_pkg::OFFSET_W-1:0];
            lpis_pkg::CFG_FIXED_LEN:   fixed_len_q   = value[lpis_pkg::COUNT_W-1:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_reg_write(logic [lpis_pkg::CFG_IDX_W-1:0] idx,
                                          logic [lpis_pkg::BASE_W-1:0] value);
        step_t s;
        s           = '{default: '0};
        s.is_reg    = 1'b1;
        s.reg_index = idx;
        s.reg_value = value;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    function automatic void add_item(bit pin, logic [1:0] cmd,
                                     logic [lpis_pkg::OFFSET_W-1:0] offset,
                                     logic [lpis_pkg::COUNT_W-1:0] count, bit live,
                                     logic [lpis_pkg::SLOT_W-1:0] slot,
                                     logic [1:0] st = lpis_pkg::STAT_OK,
                                     longint pidx = 0, bit iv = 1'b0);
        step_t s;
        s                    = '{default: '0};
        s.stim.command       = cmd;
        s.stim.value_offset  = offset;
        s.stim.value_count   = count;
        s.stim.element_valid = live;
        s.stim.slot_address  = slot;
        s.pinned             = pin;
        s.golden.status      = st;
        s.golden.parent_index = lpis_pkg::PIDX_W'(pidx);
        s.golden.index_valid = iv;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    task automatic fill_arrays(input int goal);
        logic [63:0]   noise;
        logic [1:0]    pick_mode;
        lpis_pkg::in_t it;
        int            cursor;
        int            span;
        int            pick;
        while (items_sent < goal)
        begin
            pick_mode = ($urandom_range(0, 19) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
            write_reg(lpis_pkg::CFG_LIST_MODE, lpis_pkg::BASE_W'(pick_mode));
            noise = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       write_reg(lpis_pkg::CFG_BASE_PARENT, '0);
                1:       write_reg(lpis_pkg::CFG_BASE_PARENT, '1);
                default: write_reg(lpis_pkg::CFG_BASE_PARENT, noise[lpis_pkg::BASE_W-1:0]);
            endcase
            // keep headroom so that base plus slot never wraps the offset field
            if ($urandom_range(0, 3) == 0)
                write_reg(lpis_pkg::CFG_VALUES_BASE, '0);
            else
                write_reg(lpis_pkg::CFG_VALUES_BASE,
                          lpis_pkg::BASE_W'($urandom_range(0, 32'h7FFF_DFFF)));
            pick = $urandom_range(0, 31);
            if (pick < 2)
                write_reg(lpis_pkg::CFG_FIXED_LEN, '0);
            else if (pick < 3)
                write_reg(lpis_pkg::CFG_FIXED_LEN, lpis_pkg::BASE_W'(lpis_pkg::MAX_VALUES));
            else
                write_reg(lpis_pkg::CFG_FIXED_LEN, lpis_pkg::BASE_W'($urandom_range(1, 24)));

            it         = '0;
            it.command = lpis_pkg::CMD_CLEAR;
            send_item(it, 1'b0, '0);
            items_sent++;
            cursor = 0;

            repeat ($urandom_range(8, 32))
            begin
                noise = {$urandom, $urandom};
                it    = noise[$bits(lpis_pkg::in_t)-1:0];
                pick  = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // next element of a well-formed list
                    span = ($urandom_range(0, 63) == 0) ? $urandom_range(256, 2048)
                                                        : $urandom_range(0, 12);
                    if (span > lpis_pkg::MAX_VALUES - cursor)
                        span = lpis_pkg::MAX_VALUES - cursor;
                    it.command       = lpis_pkg::CMD_ELEMENT;
                    it.value_offset  = lpis_pkg::OFFSET_W'(values_base_q + cursor);
                    it.value_count   = lpis_pkg::COUNT_W'(span);
                    it.element_valid = ($urandom_range(0, 3) != 0);
                    if (mode_q == lpis_pkg::MODE_LIST
                        || (mode_q == lpis_pkg::MODE_VIEW && it.element_valid))
                        cursor += span;
                    else if (mode_q == lpis_pkg::MODE_FIXED && it.element_valid
                             && cursor + fixed_len_q <= lpis_pkg::MAX_VALUES)
                        cursor += fixed_len_q;
                end
                else if (pick < 66)
                begin
                    // reuse values already claimed
                    it.command       = lpis_pkg::CMD_ELEMENT;
                    it.value_offset  = lpis_pkg::OFFSET_W'(values_base_q
                                                           + $urandom_range(0, cursor));
                    it.value_count   = lpis_pkg::COUNT_W'($urandom_range(1, 4));
                    it.element_valid = 1'b1;
                end
                else if (pick < 94)
                begin
                    it.command = lpis_pkg::CMD_READ;
                    if ($urandom_range(0, 7) != 0)
                        it.slot_address = lpis_pkg::SLOT_W'($urandom_range(0,
                                              (cursor < lpis_pkg::MAX_VALUES)
                                              ? cursor : lpis_pkg::MAX_VALUES - 1));
                end
                send_item(it, 1'b0, '0);
                if (it.command != CMD_SPARE)
                    items_sent++;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        pin_now    = 1'b0;
        pin_golden = '0;
        mismatches = 0;
        items_sent = 0;
        idle_pct   = 35;
        mode_q        = lpis_pkg::MODE_LIST;
        base_parent_q = '0;
        values_base_q = '0;
        fixed_len_q   = lpis_pkg::COUNT_W'(1);
        clear_shadow();

        // nothing claimed straight after reset
        add_item(1, lpis_pkg::CMD_READ,    0, 0, 0, 0, lpis_pkg::STAT_OK, -1, 0);
        // an empty element writes nothing but is counted
        add_item(1, lpis_pkg::CMD_ELEMENT, 0, 0, 1, 0, lpis_pkg::STAT_OK, 0, 0);
        // offset-list mode claims the range of a null element as well
        add_item(0, lpis_pkg::CMD_ELEMENT, 0, 3, 0, 0);
        add_item(1, lpis_pkg::CMD_READ,    0, 0, 0, 2, lpis_pkg::STAT_OK, 1, 1);
        add_item(1, lpis_pkg::CMD_READ,    0, 0, 0, 4095, lpis_pkg::STAT_OK, -1, 0);
        add_reg_write(lpis_pkg::CFG_BASE_PARENT, '1);
        add_item(0, lpis_pkg::CMD_ELEMENT, 4093, 3, 1, 0);
        add_item(0, lpis_pkg::CMD_ELEMENT, 3, 4090, 1, 0);
        add_item(0, lpis_pkg::CMD_READ,    0, 0, 0, 4095);
        // overlap, then the error holds and blocks further elements
        add_item(1, lpis_pkg::CMD_ELEMENT, 100, 1, 1, 0, lpis_pkg::STAT_SHARED);
        add_item(1, lpis_pkg::CMD_ELEMENT, 0, 0, 1, 0, lpis_pkg::STAT_SHARED);
        add_item(1, CMD_SPARE,             '1, '1, 1, '1, lpis_pkg::STAT_SHARED);
        add_item(1, lpis_pkg::CMD_CLEAR,   0, 0, 0, 0, lpis_pkg::STAT_OK);
        add_item(1, lpis_pkg::CMD_ELEMENT, 4096, 1, 1, 0, lpis_pkg::STAT_RANGE);
        add_item(1, lpis_pkg::CMD_CLEAR,   0, 0, 0, 0, lpis_pkg::STAT_OK);
        add_item(1, lpis_pkg::CMD_ELEMENT, 0, '1, 1, 0, lpis_pkg::STAT_RANGE);
        add_reg_write(lpis_pkg::CFG_VALUES_BASE, lpis_pkg::BASE_W'(32'h7FFF_FFFF));
        add_item(1, lpis_pkg::CMD_CLEAR,   0, 0, 0, 0, lpis_pkg::STAT_OK);
        add_item(0, lpis_pkg::CMD_ELEMENT, 31'h7FFF_FFFF, 1, 1, 0);
        // offset below the base of the values
        add_item(1, lpis_pkg::CMD_ELEMENT, 31'h7FFF_FFFE, 1, 1, 0, lpis_pkg::STAT_RANGE);
        add_reg_write(lpis_pkg::CFG_LIST_MODE, lpis_pkg::BASE_W'(lpis_pkg::MODE_VIEW));
        add_reg_write(lpis_pkg::CFG_VALUES_BASE, '0);
        add_reg_write(lpis_pkg::CFG_BASE_PARENT, '0);
        add_item(1, lpis_pkg::CMD_CLEAR,   0, 0, 0, 0, lpis_pkg::STAT_OK);
        // list view skips a null element
        add_item(0, lpis_pkg::CMD_ELEMENT, 1, 1, 0, 0);
        add_item(1, lpis_pkg::CMD_READ,    0, 0, 0, 1, lpis_pkg::STAT_OK, -1, 0);
        add_reg_write(lpis_pkg::CFG_LIST_MODE, lpis_pkg::BASE_W'(lpis_pkg::MODE_FIXED));
        add_reg_write(lpis_pkg::CFG_FIXED_LEN, lpis_pkg::BASE_W'(lpis_pkg::MAX_VALUES));
        add_item(0, lpis_pkg::CMD_ELEMENT, 0, 0, 0, 0);
        add_item(0, lpis_pkg::CMD_ELEMENT, 0, 0, 1, 0);
        add_item(1, lpis_pkg::CMD_ELEMENT, 0, 0, 1, 0, lpis_pkg::STAT_RANGE);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_reg)
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            else
            begin
                send_item(directed_steps[i].stim, directed_steps[i].pinned,
                          directed_steps[i].golden);
                items_sent++;
            end
        end

        idle_pct = 35;
        fill_arrays(ITEM_GOAL / 3);
        idle_pct = 83;
        fill_arrays(2 * ITEM_GOAL / 3);
        idle_pct = 0;
        fill_arrays(ITEM_GOAL);

        drain();
        repeat (16) @(negedge clk);
        if (mismatches == 0 && parent_results_due.size() == 0)
            $display("list_parent_index_scatter_tb: PASS");
        else
            $display("list_parent_index_scatter_tb: FAIL");
        $finish;
    end

endmodule
